### hdl/cascaded_context_byte_predictor_assert.svh
// assertion macros used by the predictor back end
`ifndef CASCADED_CONTEXT_BYTE_PREDICTOR_ASSERT_SVH
`define CASCADED_CONTEXT_BYTE_PREDICTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CCBP_ASSERT_IMPL(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CCBP_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CCBP_ASSERT_IMPL(name, clock, resetn, ante, cons)
`define CCBP_ASSERT_NEXT(name, clock, resetn, ante, cons)
`endif
`endif

### hdl/ccbp_pkg.sv
package ccbp_pkg;

    localparam int TABLE_DIM_DEF    = 256;
    localparam int FAST_PERIOD_DEF  = 100;
    localparam int PERIOD_RATIO_DEF = 10;
    localparam int FIFO_DEPTH       = 2;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    localparam logic [2:0] ORDER_FAST   = 3'd2;
    localparam logic [2:0] ORDER_MIDDLE = 3'd4;
    localparam logic [2:0] ORDER_SLOW   = 3'd6;
    localparam logic [2:0] CTX_MAX      = 3'd6;

    localparam logic [7:0] CONF_MAX   = 8'd255;
    localparam logic [7:0] RATE_HI    = 8'd160;
    localparam logic [7:0] RATE_LO    = 8'd64;
    localparam logic [7:0] TRUST_INIT = 8'd128;
    localparam logic [7:0] TRUST_MAX  = 8'd255;

    // byte value reduced modulo the table dimension (dimension 16..256)
    function automatic logic [7:0] mod_dim(input logic [7:0] x, input logic [8:0] dim);
        logic [11:0] r;
        logic [11:0] t;
        r = {4'd0, x};
        for (int s = 3; s >= 0; s--)
        begin
            t = {3'd0, dim} << s;
            if (r >= t)
            begin
                r = r - t;
            end
        end
        return r[7:0];
    endfunction

    function automatic logic [15:0] cell_update(input logic [15:0] entry,
                                                input logic [7:0] actual);
        logic [7:0] pred;
        logic [7:0] conf;
        pred = entry[7:0];
        conf = entry[15:8];
        if (pred == actual)
        begin
            if (conf != CONF_MAX)
            begin
                conf = conf + 8'd1;
            end
        end
        else if (conf > 8'd1)
        begin
            conf = conf - 8'd1;
        end
        else
        begin
            pred = actual;
            conf = 8'd1;
        end
        return {conf, pred};
    endfunction

endpackage

### hdl/cascaded_context_byte_predictor.sv
// channel | direction | fields
// s_*     | in        | tuser: action; tdata: context_length, ctx_byte_1..6, actual_byte
// m_*     | out       | tdata: predicted_byte, confidence, fast/middle/slow trust
// after reset the tables are cleared cell by cell, s_tready low meanwhile
// front end: an accept state, a hash state (one context byte per cycle), then a queue push that waits while full
// back end: read, evaluate and output states per item, plus a divide and a cascade state per trust update
// (every FAST_PERIOD feeds, two in a row every FAST_PERIOD*PERIOD_RATIO feeds)
// the front end takes no new item until the last is pushed, so its serial hash sets the sustained rate
// a 2-entry queue and the output register let either side stall alone
module cascaded_context_byte_predictor #(
    parameter int TABLE_DIM    = ccbp_pkg::TABLE_DIM_DEF,
    parameter int FAST_PERIOD  = ccbp_pkg::FAST_PERIOD_DEF,
    parameter int PERIOD_RATIO = ccbp_pkg::PERIOD_RATIO_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // context_length, ctx_byte_1..ctx_byte_6, actual_byte
    input  logic [0:0]  s_tuser,  // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // predicted_byte, confidence, fast, middle, slow trust
);

    localparam int AW = $clog2(TABLE_DIM*TABLE_DIM);
    localparam int QW = 1 + 8 + 3*AW;

    logic          clear_done;
    logic          push, full, pop, empty;
    logic          f_action;
    logic [7:0]    f_actual;
    logic [AW-1:0] f_fast, f_middle, f_slow;
    logic [QW-1:0] q_in, q_out;

    ccbp_front #(
        .TABLE_DIM (TABLE_DIM)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable         (clear_done),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .push           (push),
        .full           (full),
        .job_action     (f_action),
        .job_actual     (f_actual),
        .job_fast_idx   (f_fast),
        .job_middle_idx (f_middle),
        .job_slow_idx   (f_slow)
    );

    assign q_in = {f_action, f_actual, f_fast, f_middle, f_slow};

    ccbp_fifo #(
        .WIDTH (QW),
        .DEPTH (ccbp_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (full),
        .pop       (pop),
        .pop_data  (q_out),
        .empty     (empty)
    );

    ccbp_back #(
        .TABLE_DIM    (TABLE_DIM),
        .FAST_PERIOD  (FAST_PERIOD),
        .PERIOD_RATIO (PERIOD_RATIO)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .clear_done     (clear_done),
        .empty          (empty),
        .pop            (pop),
        .job_action     (q_out[QW-1]),
        .job_actual     (q_out[QW-2 -: 8]),
        .job_fast_idx   (q_out[3*AW-1 -: AW]),
        .job_middle_idx (q_out[2*AW-1 -: AW]),
        .job_slow_idx   (q_out[AW-1:0]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

### hdl/ccbp_ram.sv
module ccbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/ccbp_fifo.sv
module ccbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ccbp_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + (PW+1)'(1);
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule

### hdl/ccbp_front.sv
module ccbp_front #(
    parameter int TABLE_DIM = ccbp_pkg::TABLE_DIM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 enable,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [63:0]                          s_tdata,
    input  logic [0:0]                           s_tuser,
    output logic                                 push,
    input  logic                                 full,
    output logic                                 job_action,
    output logic [7:0]                           job_actual,
    output logic [$clog2(TABLE_DIM*TABLE_DIM)-1:0] job_fast_idx,
    output logic [$clog2(TABLE_DIM*TABLE_DIM)-1:0] job_middle_idx,
    output logic [$clog2(TABLE_DIM*TABLE_DIM)-1:0] job_slow_idx
);

    localparam int AW = $clog2(TABLE_DIM*TABLE_DIM);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_HASH = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [7:0]  bytes_reg [6];
    logic [2:0]  len_reg;
    logic        action_reg;
    logic [7:0]  actual_reg;
    logic [2:0]  step_reg;
    logic [31:0] hash_reg  [3];
    logic [31:0] hash_next [3];
    logic [2:0]  use_len   [3];
    logic [2:0]  order     [3];
    logic [AW-1:0] idx     [3];
    logic [2:0]  in_len;

    assign order[0] = ccbp_pkg::ORDER_FAST;
    assign order[1] = ccbp_pkg::ORDER_MIDDLE;
    assign order[2] = ccbp_pkg::ORDER_SLOW;

    assign in_len   = (s_tdata[2:0] > ccbp_pkg::CTX_MAX) ? ccbp_pkg::CTX_MAX : s_tdata[2:0];
    assign s_tready = enable && (state_reg == F_IDLE);

    always_comb
    begin
        logic [2:0] sel;
        logic [7:0] row;
        logic [7:0] col;
        for (int k = 0; k < 3; k++)
        begin
            use_len[k]   = (len_reg < order[k]) ? len_reg : order[k];
            sel          = use_len[k] - 3'd1 - step_reg;
            hash_next[k] = hash_reg[k];
            if (step_reg < use_len[k])
            begin
                hash_next[k] = (hash_reg[k] ^ {24'd0, bytes_reg[sel]}) * ccbp_pkg::FNV_PRIME;
            end
            row    = ccbp_pkg::mod_dim(hash_reg[k][15:8], 9'(TABLE_DIM));
            col    = ccbp_pkg::mod_dim(hash_reg[k][7:0], 9'(TABLE_DIM));
            idx[k] = (use_len[k] == 3'd0) ? '0
                   : AW'(AW'(row) * AW'(TABLE_DIM) + AW'(col));
        end
    end

    assign push           = (state_reg == F_PUSH);
    assign job_action     = action_reg;
    assign job_actual     = actual_reg;
    assign job_fast_idx   = idx[0];
    assign job_middle_idx = idx[1];
    assign job_slow_idx   = idx[2];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                if (step_reg == ccbp_pkg::CTX_MAX - 3'd1)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE)
        begin
            for (int i = 0; i < 6; i++)
            begin
                bytes_reg[i] <= s_tdata[3 + 8*i +: 8];
            end
            len_reg    <= in_len;
            action_reg <= s_tuser[0];
            actual_reg <= s_tdata[58:51];
            step_reg   <= '0;
            for (int k = 0; k < 3; k++)
            begin
                hash_reg[k] <= ccbp_pkg::FNV_OFFSET;
            end
        end
        else if (state_reg == F_HASH)
        begin
            step_reg <= step_reg + 3'd1;
            for (int k = 0; k < 3; k++)
            begin
                hash_reg[k] <= hash_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/ccbp_back.sv
`include "cascaded_context_byte_predictor_assert.svh"

module ccbp_back #(
    parameter int TABLE_DIM    = ccbp_pkg::TABLE_DIM_DEF,
    parameter int FAST_PERIOD  = ccbp_pkg::FAST_PERIOD_DEF,
    parameter int PERIOD_RATIO = ccbp_pkg::PERIOD_RATIO_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    output logic                                   clear_done,
    input  logic                                   empty,
    output logic                                   pop,
    input  logic                                   job_action,
    input  logic [7:0]                             job_actual,
    input  logic [$clog2(TABLE_DIM*TABLE_DIM)-1:0] job_fast_idx,
    input  logic [$clog2(TABLE_DIM*TABLE_DIM)-1:0] job_middle_idx,
    input  logic [$clog2(TABLE_DIM*TABLE_DIM)-1:0] job_slow_idx,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [39:0]                            m_tdata
);

    localparam int CELLS      = TABLE_DIM * TABLE_DIM;
    localparam int AW         = $clog2(CELLS);
    localparam int MID_PERIOD = FAST_PERIOD * PERIOD_RATIO;
    localparam int FTW        = $clog2(FAST_PERIOD + 1);
    localparam int MTW        = $clog2(PERIOD_RATIO + 1);
    localparam int MHW        = $clog2(MID_PERIOD + 1);
    localparam int RW         = $clog2(MID_PERIOD * 256 + 1);
    localparam int FL         = $clog2(FAST_PERIOD);
    localparam int ML         = $clog2(MID_PERIOD);
    localparam int FS         = RW + FL;
    localparam int MS         = RW + ML;
    localparam int MW         = RW + 2;
    localparam logic [MW-1:0] F_RECIP =
        MW'(((64'd1 << FS) + 64'(FAST_PERIOD) - 64'd1) / 64'(FAST_PERIOD));
    localparam logic [MW-1:0] M_RECIP =
        MW'(((64'd1 << MS) + 64'(MID_PERIOD) - 64'd1) / 64'(MID_PERIOD));

    typedef enum logic [6:0] {
        B_CLEAR = 7'b0000001,
        B_IDLE  = 7'b0000010,
        B_READ  = 7'b0000100,
        B_EVAL  = 7'b0001000,
        B_DIV   = 7'b0010000,
        B_CASC  = 7'b0100000,
        B_OUT   = 7'b1000000
    } back_state_t;

    back_state_t state_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic           action_reg;
    logic [7:0]     actual_reg;
    logic [AW-1:0]  idx_reg [3];
    logic [15:0]    rd_cell [3];
    logic [15:0]    wr_cell [3];
    logic           tbl_we;
    logic [AW-1:0]  wr_addr [3];
    logic [7:0]     fast_trust_reg;
    logic [7:0]     middle_trust_reg;
    logic [7:0]     slow_trust_reg;
    logic [FTW-1:0] fast_tick_reg;
    logic [MTW-1:0] middle_tick_reg;
    logic [FTW-1:0] fast_hits_reg;
    logic [MHW-1:0] middle_hits_reg;
    logic [7:0]     pred_reg;
    logic [7:0]     conf_reg;
    logic [RW-1:0]  rem_reg;
    logic [7:0]     quo_reg;
    logic           div_mid_reg;
    logic           mid_pending_reg;
    logic           out_valid_reg;
    logic [39:0]    out_data_reg;

    logic [15:0]    wf, wm, ws;
    logic [7:0]     win_pred, win_conf;
    logic           hit_f, hit_m;
    logic [FTW-1:0] fast_tick_inc;
    logic [MTW-1:0] middle_tick_inc;
    logic [FTW-1:0] fast_hits_new;
    logic [MHW-1:0] middle_hits_new;
    logic [RW+MW-1:0] div_prod;
    logic [7:0]     div_quo;
    logic [7:0]     casc_f, casc_s;
    logic [7:0]     new_f, new_s;
    logic [9:0]     f_sum;
    logic [8:0]     s_sum;
    logic [7:0]     s_delta;

    for (genvar k = 0; k < 3; k++)
    begin : g_tbl
        ccbp_ram #(
            .WIDTH (16),
            .DEPTH (CELLS)
        ) u_ram (
            .clk   (clk),
            .we    (tbl_we),
            .waddr (wr_addr[k]),
            .wdata (wr_cell[k]),
            .raddr (idx_reg[k]),
            .rdata (rd_cell[k])
        );
        assign wr_addr[k] = (state_reg == B_CLEAR) ? clr_addr_reg : idx_reg[k];
        assign wr_cell[k] = (state_reg == B_CLEAR) ? 16'd0
                          : ccbp_pkg::cell_update(rd_cell[k], actual_reg);
    end

    assign tbl_we     = (state_reg == B_CLEAR) || ((state_reg == B_EVAL) && action_reg);
    assign clear_done = (state_reg != B_CLEAR);
    assign pop        = (state_reg == B_IDLE) && !empty;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    assign wf = 16'(fast_trust_reg)   * 16'(rd_cell[0][15:8]);
    assign wm = 16'(middle_trust_reg) * 16'(rd_cell[1][15:8]);
    assign ws = 16'(slow_trust_reg)   * 16'(rd_cell[2][15:8]);

    always_comb
    begin
        if (wf >= wm && wf >= ws)
        begin
            win_pred = rd_cell[0][7:0];
            win_conf = rd_cell[0][15:8];
        end
        else if (wm >= ws)
        begin
            win_pred = rd_cell[1][7:0];
            win_conf = rd_cell[1][15:8];
        end
        else
        begin
            win_pred = rd_cell[2][7:0];
            win_conf = rd_cell[2][15:8];
        end
    end

    assign hit_f           = (rd_cell[0][7:0] == actual_reg);
    assign hit_m           = (rd_cell[1][7:0] == actual_reg);
    assign fast_tick_inc   = fast_tick_reg + FTW'(1);
    assign middle_tick_inc = middle_tick_reg + MTW'(1);
    assign fast_hits_new   = fast_hits_reg + FTW'(hit_f);
    assign middle_hits_new = middle_hits_reg + MHW'(hit_m);

    // hits * 255 over the period length, by multiplying with a scaled reciprocal
    assign div_prod = (RW+MW)'(rem_reg) * (RW+MW)'(div_mid_reg ? M_RECIP : F_RECIP);
    assign div_quo  = div_mid_reg ? 8'(div_prod >> MS) : 8'(div_prod >> FS);

    assign casc_f = div_mid_reg ? middle_trust_reg : fast_trust_reg;
    assign casc_s = div_mid_reg ? slow_trust_reg : middle_trust_reg;
    assign f_sum  = 10'(casc_f) * 10'd3 + 10'(quo_reg) + 10'd2;
    assign new_f  = f_sum[9:2];

    always_comb
    begin
        s_delta = '0;
        s_sum   = '0;
        new_s   = casc_s;
        if (quo_reg > ccbp_pkg::RATE_HI)
        begin
            s_delta = (quo_reg - ccbp_pkg::RATE_HI) >> 3;
            s_sum   = 9'(casc_s) + 9'(s_delta);
            new_s   = s_sum[8] ? ccbp_pkg::TRUST_MAX : s_sum[7:0];
        end
        else if (quo_reg < ccbp_pkg::RATE_LO)
        begin
            s_delta = (ccbp_pkg::RATE_LO - quo_reg) >> 4;
            new_s   = (casc_s >= s_delta) ? casc_s - s_delta : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            action_reg <= job_action;
            actual_reg <= job_actual;
            idx_reg[0] <= job_fast_idx;
            idx_reg[1] <= job_middle_idx;
            idx_reg[2] <= job_slow_idx;
        end
        if (state_reg == B_EVAL)
        begin
            pred_reg <= win_pred;
            conf_reg <= win_conf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_CLEAR;
            clr_addr_reg     <= '0;
            fast_trust_reg   <= ccbp_pkg::TRUST_INIT;
            middle_trust_reg <= ccbp_pkg::TRUST_INIT;
            slow_trust_reg   <= ccbp_pkg::TRUST_INIT;
            fast_tick_reg    <= '0;
            middle_tick_reg  <= '0;
            fast_hits_reg    <= '0;
            middle_hits_reg  <= '0;
            rem_reg          <= '0;
            quo_reg          <= '0;
            div_mid_reg      <= 1'b0;
            mid_pending_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && (state_reg != B_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(CELLS - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        state_reg <= B_READ;
                    end
                end
                B_READ:
                begin
                    state_reg <= B_EVAL;
                end
                B_EVAL:
                begin
                    state_reg <= B_OUT;
                    if (action_reg)
                    begin
                        middle_hits_reg <= middle_hits_new;
                        if (fast_tick_inc >= FTW'(FAST_PERIOD))
                        begin
                            fast_tick_reg   <= '0;
                            fast_hits_reg   <= '0;
                            rem_reg         <= (RW'(fast_hits_new) << 8) - RW'(fast_hits_new);
                            quo_reg         <= '0;
                            div_mid_reg     <= 1'b0;
                            state_reg       <= B_DIV;
                            if (middle_tick_inc >= MTW'(PERIOD_RATIO))
                            begin
                                middle_tick_reg <= '0;
                                mid_pending_reg <= 1'b1;
                            end
                            else
                            begin
                                middle_tick_reg <= middle_tick_inc;
                                mid_pending_reg <= 1'b0;
                            end
                        end
                        else
                        begin
                            fast_tick_reg <= fast_tick_inc;
                            fast_hits_reg <= fast_hits_new;
                        end
                    end
                end
                B_DIV:
                begin
                    quo_reg   <= div_quo;
                    state_reg <= B_CASC;
                end
                B_CASC:
                begin
                    if (!div_mid_reg)
                    begin
                        fast_trust_reg   <= new_f;
                        middle_trust_reg <= new_s;
                        if (mid_pending_reg)
                        begin
                            mid_pending_reg <= 1'b0;
                            middle_hits_reg <= '0;
                            rem_reg         <= (RW'(middle_hits_reg) << 8)
                                             - RW'(middle_hits_reg);
                            quo_reg         <= '0;
                            div_mid_reg     <= 1'b1;
                            state_reg       <= B_DIV;
                        end
                        else
                        begin
                            state_reg <= B_OUT;
                        end
                    end
                    else
                    begin
                        middle_trust_reg <= new_f;
                        slow_trust_reg   <= new_s;
                        state_reg        <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {slow_trust_reg, middle_trust_reg, fast_trust_reg,
                                          conf_reg, pred_reg};
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    `CCBP_ASSERT_IMPL(a_write_only_on_feed, clk, rst_n, tbl_we && (state_reg != B_CLEAR), action_reg)
    `CCBP_ASSERT_NEXT(a_div_ends_in_casc, clk, rst_n, state_reg == B_DIV, state_reg == B_CASC)
    `CCBP_ASSERT_IMPL(a_result_from_out, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == B_OUT)

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_RANDOM   = 1500;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int TAIL_CYCLES  = 64;
    localparam int CELLS        = ccbp_pkg::TABLE_DIM_DEF * ccbp_pkg::TABLE_DIM_DEF;

    typedef enum logic [0:0] {
        ACT_PREDICT = 1'b0,
        ACT_FEED    = 1'b1
    } action_t;

    typedef struct packed {
        logic [7:0] slow_trust;
        logic [7:0] middle_trust;
        logic [7:0] fast_trust;
        logic [7:0] confidence;
        logic [7:0] predicted_byte;
    } prediction_t;

    typedef struct {
        action_t    act;
        logic [2:0] ctx_len;
        logic [7:0] ctx [6];
        logic [7:0] actual;
        logic       has_expect;
        prediction_t expect_val;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // context_length, ctx_byte_1..ctx_byte_6, actual_byte
    logic [0:0]  s_tuser;   // action
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // predicted_byte, confidence, fast, middle, slow trust

    cascaded_context_byte_predictor DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predictor state
    logic [15:0] fast_tbl [CELLS];
    logic [15:0] middle_tbl [CELLS];
    logic [15:0] slow_tbl [CELLS];
    int unsigned fast_feeds;
    int unsigned middle_periods;
    int unsigned fast_hit_cnt;
    int unsigned fast_seen;
    int unsigned middle_hit_cnt;
    int unsigned middle_seen;
    logic [7:0]  fast_trust_lvl;
    logic [7:0]  middle_trust_lvl;
    logic [7:0]  slow_trust_lvl;

    prediction_t pending_predictions [$];
    stim_row_t   directed_rows [$];

    int  mismatches;
    int  results_seen;
    int  feeds_sent;
    int  cycle_count;
    bit  quiet_sender;
    bit  quiet_receiver;
    bit  stall_receiver;
    bit  stimulus_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned context_cell(logic [7:0] ctx [6], int len, int order);
        int          use_n;
        logic [31:0] h;
        use_n = (len < order) ? len : order;
        h = ccbp_pkg::FNV_OFFSET;
        if (use_n == 0)
        begin
            return 0;
        end
        for (int i = use_n; i > 0; i--)
        begin
            h = (h ^ {24'd0, ctx[i-1]}) * ccbp_pkg::FNV_PRIME;
        end
        return h[15:8] * ccbp_pkg::TABLE_DIM_DEF + h[7:0];
    endfunction

    function automatic logic [15:0] train_cell(logic [15:0] entry, logic [7:0] actual,
                                               ref int unsigned hits, ref int unsigned seen);
        logic [7:0] pred;
        logic [7:0] conf;
        pred = entry[7:0];
        conf = entry[15:8];
        seen++;
        if (pred == actual)
        begin
            if (conf != 8'd255)
            begin
                conf++;
            end
            hits++;
        end
        else if (conf > 8'd1)
        begin
            conf--;
        end
        else
        begin
            pred = actual;
            conf = 8'd1;
        end
        return {conf, pred};
    endfunction

    function automatic void shift_trust(ref int unsigned hits, ref int unsigned seen,
                                        ref logic [7:0] near_tr, ref logic [7:0] far_tr);
        int unsigned rate;
        int unsigned t;
        rate = (seen > 0) ? ((hits * 255) / seen) & 8'hFF : 0;
        near_tr = 8'((near_tr * 3 + rate + 2) >> 2);
        if (rate > 160)
        begin
            t = far_tr + ((rate - 160) >> 3);
            far_tr = (t > 255) ? 8'd255 : 8'(t);
        end
        else if (rate < 64)
        begin
            t = (64 - rate) >> 4;
            far_tr = (far_tr >= t) ? 8'(far_tr - t) : 8'd0;
        end
        hits = 0;
        seen = 0;
    endfunction

    function automatic prediction_t predict_byte(stim_row_t r);
        int unsigned fi, mi, si, len;
        int unsigned wf, wm, ws;
        prediction_t p;
        len = (r.ctx_len > 6) ? 6 : r.ctx_len;
        fi = context_cell(r.ctx, len, 2);
        mi = context_cell(r.ctx, len, 4);
        si = context_cell(r.ctx, len, 6);
        wf = fast_trust_lvl * fast_tbl[fi][15:8];
        wm = middle_trust_lvl * middle_tbl[mi][15:8];
        ws = slow_trust_lvl * slow_tbl[si][15:8];
        if (wf >= wm && wf >= ws)
        begin
            p.predicted_byte = fast_tbl[fi][7:0];
            p.confidence     = fast_tbl[fi][15:8];
        end
        else if (wm >= ws)
        begin
            p.predicted_byte = middle_tbl[mi][7:0];
            p.confidence     = middle_tbl[mi][15:8];
        end
        else
        begin
            p.predicted_byte = slow_tbl[si][7:0];
            p.confidence     = slow_tbl[si][15:8];
        end
        if (r.act == ACT_FEED)
        begin
            int unsigned slow_h;
            int unsigned slow_s;
            slow_h = 0;
            slow_s = 0;
            fast_tbl[fi]   = train_cell(fast_tbl[fi], r.actual, fast_hit_cnt, fast_seen);
            middle_tbl[mi] = train_cell(middle_tbl[mi], r.actual, middle_hit_cnt, middle_seen);
            slow_tbl[si]   = train_cell(slow_tbl[si], r.actual, slow_h, slow_s);
            fast_feeds++;
            if (fast_feeds >= ccbp_pkg::FAST_PERIOD_DEF)
            begin
                shift_trust(fast_hit_cnt, fast_seen, fast_trust_lvl, middle_trust_lvl);
                fast_feeds = 0;
                middle_periods++;
                if (middle_periods >= ccbp_pkg::PERIOD_RATIO_DEF)
                begin
                    shift_trust(middle_hit_cnt, middle_seen, middle_trust_lvl, slow_trust_lvl);
                    middle_periods = 0;
                end
            end
        end
        p.fast_trust   = fast_trust_lvl;
        p.middle_trust = middle_trust_lvl;
        p.slow_trust   = slow_trust_lvl;
        return p;
    endfunction

    function automatic stim_row_t make_row(action_t act, int len, logic [47:0] ctx,
                                           logic [7:0] actual);
        stim_row_t r;
        r.act     = act;
        r.ctx_len = 3'(len);
        for (int i = 0; i < 6; i++)
        begin
            r.ctx[i] = ctx[8*i +: 8];
        end
        r.actual     = actual;
        r.has_expect = 1'b0;
        r.expect_val = '0;
        return r;
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t r;
        int        k;
        k = $urandom_range(0, 99);
        // mostly a small set of recurring contexts so cells train up
        if (k < 70)
        begin
            r = make_row(k < 60 ? ACT_FEED : ACT_PREDICT, $urandom_range(0, 7),
                         {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                          8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                          8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))},
                         8'($urandom_range(0, 3) * 85));
        end
        else
        begin
            r = make_row(action_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                         48'({$urandom, $urandom}), 8'($urandom));
        end
        return r;
    endfunction

    task automatic send_row(stim_row_t r);
        prediction_t p;
        s_tvalid <= 1'b1;
        s_tuser  <= r.act;
        s_tdata  <= {5'd0, r.actual, r.ctx[5], r.ctx[4], r.ctx[3], r.ctx[2], r.ctx[1],
                     r.ctx[0], r.ctx_len};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        p = predict_byte(r);
        if (r.has_expect && p != r.expect_val)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("directed row disagrees with predictor: %h vs %h", r.expect_val, p);
            end
        end
        pending_predictions.push_back(p);
        if (r.act == ACT_FEED)
        begin
            feeds_sent++;
        end
        if (!quiet_sender && $urandom_range(0, 99) < 22)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    initial
    begin
        stim_row_t r;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        quiet_sender   = 1'b0;
        quiet_receiver = 1'b0;
        stall_receiver = 1'b0;
        stimulus_done  = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        feeds_sent     = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            fast_tbl[i]   = '0;
            middle_tbl[i] = '0;
            slow_tbl[i]   = '0;
        end
        fast_feeds       = 0;
        middle_periods   = 0;
        fast_hit_cnt     = 0;
        fast_seen        = 0;
        middle_hit_cnt   = 0;
        middle_seen      = 0;
        fast_trust_lvl   = ccbp_pkg::TRUST_INIT;
        middle_trust_lvl = ccbp_pkg::TRUST_INIT;
        slow_trust_lvl   = ccbp_pkg::TRUST_INIT;

        // cleared tables: predict gives zero byte, zero confidence, initial trusts
        r = make_row(ACT_PREDICT, 0, 48'h0, 8'h00);
        r.has_expect = 1'b1;
        r.expect_val = {ccbp_pkg::TRUST_INIT, ccbp_pkg::TRUST_INIT, ccbp_pkg::TRUST_INIT,
                        8'd0, 8'd0};
        directed_rows.push_back(r);
        r = make_row(ACT_PREDICT, 6, 48'hFFFF_FFFF_FFFF, 8'hFF);
        r.has_expect = 1'b1;
        r.expect_val = {ccbp_pkg::TRUST_INIT, ccbp_pkg::TRUST_INIT, ccbp_pkg::TRUST_INIT,
                        8'd0, 8'd0};
        directed_rows.push_back(r);
        // empty context feeds, then hit, then length seven acting as six
        directed_rows.push_back(make_row(ACT_FEED, 0, 48'h0, 8'hFF));
        directed_rows.push_back(make_row(ACT_FEED, 0, 48'h0, 8'hFF));
        directed_rows.push_back(make_row(ACT_PREDICT, 0, 48'h1234, 8'h00));
        directed_rows.push_back(make_row(ACT_FEED, 6, 48'hA5A5_5A5A_0102, 8'h80));
        directed_rows.push_back(make_row(ACT_PREDICT, 7, 48'hA5A5_5A5A_0102, 8'h00));
        directed_rows.push_back(make_row(ACT_FEED, 7, 48'hA5A5_5A5A_0102, 8'h80));
        directed_rows.push_back(make_row(ACT_FEED, 6, 48'hA5A5_5A5A_0102, 8'h7F));
        directed_rows.push_back(make_row(ACT_PREDICT, 6, 48'hA5A5_5A5A_0102, 8'h00));
        // same short context, different long tails: fast layer shared
        directed_rows.push_back(make_row(ACT_FEED, 2, 48'h0000_0000_0102, 8'h11));
        directed_rows.push_back(make_row(ACT_FEED, 4, 48'h0000_3344_0102, 8'h22));
        directed_rows.push_back(make_row(ACT_PREDICT, 6, 48'h5566_3344_0102, 8'h00));
        directed_rows.push_back(make_row(ACT_FEED, 1, 48'h0000_0000_00FF, 8'h00));
        directed_rows.push_back(make_row(ACT_FEED, 3, 48'h0000_00FF_FFFF, 8'h01));
        directed_rows.push_back(make_row(ACT_FEED, 5, 48'h00FF_FFFF_FFFF, 8'hFE));
        directed_rows.push_back(make_row(ACT_PREDICT, 5, 48'h00FF_FFFF_FFFF, 8'hFF));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_row(directed_rows[i]);
        end
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            quiet_sender = (n >= 300 && n < 500);
            stall_receiver = (n >= 700 && n < 720);
            send_row(random_row());
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // receiver idling and the long hold-off
    initial
    begin
        int hold;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_receiver)
            begin
                m_tready <= 1'b0;
                hold = 0;
                while (hold < 400)
                begin
                    @(posedge clk);
                    hold++;
                end
                m_tready <= 1'b1;
                wait (!stall_receiver);
            end
            else
            begin
                quiet_receiver = (results_seen >= 1000 && results_seen < 1200);
                m_tready <= quiet_receiver || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    always @(posedge clk)
    begin
        prediction_t got;
        prediction_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            results_seen++;
            if (pending_predictions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected transfer %h", got);
                end
            end
            else
            begin
                want = pending_predictions.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch #%0d: byte %h/%h conf %h/%h trust %h %h %h / %h %h %h",
                                 results_seen, want.predicted_byte, got.predicted_byte,
                                 want.confidence, got.confidence, want.fast_trust,
                                 want.middle_trust, want.slow_trust, got.fast_trust,
                                 got.middle_trust, got.slow_trust);
                    end
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("** cascaded_context_byte_predictor: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (pending_predictions.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d transfers checked, %0d feeds (trusts %0d/%0d/%0d at end)",
                 results_seen, feeds_sent, fast_trust_lvl, middle_trust_lvl, slow_trust_lvl);
        $display("covered empty and saturated contexts, ties, back-pressure, trust updates");
        if (mismatches == 0 && pending_predictions.size() == 0)
        begin
            $display("** cascaded_context_byte_predictor: PASSED **");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("** cascaded_context_byte_predictor: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/ccbp_pkg.sv
hdl/ccbp_ram.sv
hdl/ccbp_fifo.sv
hdl/ccbp_front.sv
hdl/ccbp_back.sv
hdl/cascaded_context_byte_predictor.sv
bench/tb_top.sv
